@@ src/spq_pkg.sv @@
// Package for the sorted priority queue: operation codes, sequencer states
// and field widths. No dependencies.
package spq_pkg;

  localparam int DEPTH_DEF = 16;
  localparam int VALUE_W   = 32;
  localparam int POS_W     = 4;
  localparam int CNT_W     = 5;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_FIND   = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_INS_RD,
    ST_INS_CMP,
    ST_INS_PUT,
    ST_FND_RD,
    ST_FND_CMP,
    ST_SHF_RD,
    ST_SHF_WR,
    ST_DONE
  } state_t;

endpackage

@@ src/spq_mem.sv @@
// Entry store of the sorted priority queue: one write port, one read port,
// read data registered. Depends on spq_pkg.
module spq_mem #(
  parameter int DEPTH = spq_pkg::DEPTH_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic                                clk,
  input  logic                                we,
  input  logic [AW-1:0]                       waddr,
  input  logic signed [spq_pkg::VALUE_W-1:0]  wdata,
  input  logic [AW-1:0]                       raddr,
  output logic signed [spq_pkg::VALUE_W-1:0]  rdata
);

  logic signed [spq_pkg::VALUE_W-1:0] mem [DEPTH];
  logic signed [spq_pkg::VALUE_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

@@ src/spq_ctrl.sv @@
// Sequencer of the sorted priority queue: scans the entry store one entry at a
// time, shifting entries for insert and remove. Depends on spq_pkg.
module spq_ctrl #(
  parameter int DEPTH = spq_pkg::DEPTH_DEF,
  parameter int AW    = $clog2(DEPTH),
  parameter int FW    = $clog2(DEPTH + 1)
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic [1:0]                          in_op,
  input  logic signed [spq_pkg::VALUE_W-1:0]  in_value,
  output logic                                out_valid,
  output logic                                out_ok,
  output logic [spq_pkg::POS_W-1:0]           out_position,
  output logic [spq_pkg::CNT_W-1:0]           out_count,
  output logic                                out_head_valid,
  output logic signed [spq_pkg::VALUE_W-1:0]  out_head_value,
  output logic                                mem_we,
  output logic [AW-1:0]                       mem_waddr,
  output logic signed [spq_pkg::VALUE_W-1:0]  mem_wdata,
  output logic [AW-1:0]                       mem_raddr,
  input  logic signed [spq_pkg::VALUE_W-1:0]  mem_rdata
);

  spq_pkg::state_t                    state_r, state_nxt;
  spq_pkg::op_t                       op_r;
  logic signed [spq_pkg::VALUE_W-1:0] val_r;
  logic signed [spq_pkg::VALUE_W-1:0] head_r;
  logic [AW-1:0]                      idx_r;
  logic [AW-1:0]                      pos_r;
  logic [FW-1:0]                      fill_r;
  logic                               ok_r;

  logic          accept;
  logic          le_hit;
  logic          eq_hit;
  logic          last;
  logic [FW-1:0] idx_inc;
  logic [31:0]   fill_w;
  logic [31:0]   pos_w;

  assign accept  = start && !busy;
  assign le_hit  = mem_rdata <= val_r;
  assign eq_hit  = mem_rdata == val_r;
  assign idx_inc = FW'(idx_r) + FW'(1);
  assign last    = idx_inc == fill_r;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      spq_pkg::ST_IDLE, spq_pkg::ST_DONE: begin
        if (!accept) begin
          state_nxt = spq_pkg::ST_IDLE;
        end else begin
          unique case (spq_pkg::op_t'(in_op))
            spq_pkg::OP_INSERT: begin
              if (fill_r == FW'(DEPTH)) begin
                state_nxt = spq_pkg::ST_DONE;
              end else if (fill_r == '0) begin
                state_nxt = spq_pkg::ST_INS_PUT;
              end else begin
                state_nxt = spq_pkg::ST_INS_RD;
              end
            end
            spq_pkg::OP_REMOVE, spq_pkg::OP_FIND: begin
              state_nxt = (fill_r == '0) ? spq_pkg::ST_DONE : spq_pkg::ST_FND_RD;
            end
            default: state_nxt = spq_pkg::ST_DONE;
          endcase
        end
      end
      spq_pkg::ST_INS_RD: state_nxt = spq_pkg::ST_INS_CMP;
      spq_pkg::ST_INS_CMP: begin
        if (le_hit && idx_r != '0) begin
          state_nxt = spq_pkg::ST_INS_RD;
        end else begin
          state_nxt = spq_pkg::ST_INS_PUT;
        end
      end
      spq_pkg::ST_INS_PUT: state_nxt = spq_pkg::ST_DONE;
      spq_pkg::ST_FND_RD:  state_nxt = spq_pkg::ST_FND_CMP;
      spq_pkg::ST_FND_CMP: begin
        if (eq_hit) begin
          state_nxt = (op_r == spq_pkg::OP_FIND || last) ? spq_pkg::ST_DONE
                                                         : spq_pkg::ST_SHF_RD;
        end else begin
          state_nxt = last ? spq_pkg::ST_DONE : spq_pkg::ST_FND_RD;
        end
      end
      spq_pkg::ST_SHF_RD: state_nxt = spq_pkg::ST_SHF_WR;
      spq_pkg::ST_SHF_WR: state_nxt = last ? spq_pkg::ST_DONE : spq_pkg::ST_SHF_RD;
      default:            state_nxt = spq_pkg::ST_IDLE;
    endcase
  end

  // Outputs and memory accesses.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = '0;
    mem_wdata = '0;
    mem_raddr = idx_r;
    busy      = !(state_r == spq_pkg::ST_IDLE || state_r == spq_pkg::ST_DONE);
    out_valid = state_r == spq_pkg::ST_DONE;
    unique case (state_r)
      spq_pkg::ST_INS_CMP: begin
        // Entries not above the new value move one place towards the tail.
        if (le_hit) begin
          mem_we    = 1'b1;
          mem_waddr = idx_r + AW'(1);
          mem_wdata = mem_rdata;
        end
      end
      spq_pkg::ST_INS_PUT: begin
        mem_we    = 1'b1;
        mem_waddr = pos_r;
        mem_wdata = val_r;
      end
      spq_pkg::ST_SHF_WR: begin
        mem_we    = 1'b1;
        mem_waddr = idx_r - AW'(1);
        mem_wdata = mem_rdata;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= spq_pkg::ST_IDLE;
      fill_r  <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == spq_pkg::ST_INS_PUT) begin
        fill_r <= fill_r + FW'(1);
      end else if ((state_r == spq_pkg::ST_FND_CMP && eq_hit && op_r == spq_pkg::OP_REMOVE
                    && last) || (state_r == spq_pkg::ST_SHF_WR && last)) begin
        fill_r <= fill_r - FW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      spq_pkg::ST_IDLE, spq_pkg::ST_DONE: begin
        if (accept) begin
          op_r  <= spq_pkg::op_t'(in_op);
          val_r <= in_value;
          ok_r  <= 1'b0;
          pos_r <= '0;
          // Insert scans from the tail upwards, remove and find from the head.
          idx_r <= (spq_pkg::op_t'(in_op) == spq_pkg::OP_INSERT) ?
                   AW'(fill_r - FW'(1)) : '0;
        end
      end
      spq_pkg::ST_INS_CMP: begin
        if (le_hit) begin
          if (idx_r == '0) begin
            pos_r <= '0;
          end else begin
            idx_r <= idx_r - AW'(1);
          end
        end else begin
          pos_r <= idx_r + AW'(1);
        end
      end
      spq_pkg::ST_INS_PUT: begin
        ok_r <= 1'b1;
        if (pos_r == '0) begin
          head_r <= val_r;
        end
      end
      spq_pkg::ST_FND_CMP: begin
        if (eq_hit) begin
          ok_r  <= 1'b1;
          pos_r <= idx_r;
        end
        idx_r <= idx_r + AW'(1);
      end
      spq_pkg::ST_SHF_WR: begin
        if (idx_r == AW'(1)) begin
          head_r <= mem_rdata;
        end
        idx_r <= idx_r + AW'(1);
      end
      default: ;
    endcase
  end

  assign fill_w         = 32'(fill_r);
  assign pos_w          = 32'(pos_r);
  assign out_ok         = ok_r;
  assign out_position   = pos_w[spq_pkg::POS_W-1:0];
  assign out_count      = fill_w[spq_pkg::CNT_W-1:0];
  assign out_head_valid = fill_r != '0;
  assign out_head_value = (fill_r != '0) ? head_r : '0;

endmodule

@@ src/sorted_priority_queue.sv @@
// Top level of the sorted priority queue: sequencer and entry store.
// Depends on spq_pkg, spq_mem and spq_ctrl.
//
//   Channel  Ports                               Handshake
//   input    in_op, in_value                     start high, busy low
//   result   out_ok, out_position, out_count,    out_valid, one cycle
//            out_head_valid, out_head_value
//
// Insert walks from the tail to its place, remove walks from the head to the
// match and then to the tail, find walks from the head to the match.
// Each visit is a read then a compare or write, as the store's read data is
// registered. A rejected insert or an empty-queue search gives its result in
// the cycle after it is taken. Reset clears the count and the sequencer state
// only; the store needs no clearing. The result strobe is a single cycle and
// cannot be stalled; a new item may start in it.
module sorted_priority_queue #(
  parameter int DEPTH = spq_pkg::DEPTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic [1:0]                          in_op,
  input  logic signed [spq_pkg::VALUE_W-1:0]  in_value,
  output logic                                out_valid,
  output logic                                out_ok,
  output logic [spq_pkg::POS_W-1:0]           out_position,
  output logic [spq_pkg::CNT_W-1:0]           out_count,
  output logic                                out_head_valid,
  output logic signed [spq_pkg::VALUE_W-1:0]  out_head_value
);

  localparam int AW = $clog2(DEPTH);
  localparam int FW = $clog2(DEPTH + 1);

  logic                               mem_we;
  logic [AW-1:0]                      mem_waddr;
  logic signed [spq_pkg::VALUE_W-1:0] mem_wdata;
  logic [AW-1:0]                      mem_raddr;
  logic signed [spq_pkg::VALUE_W-1:0] mem_rdata;

  spq_ctrl #(
    .DEPTH (DEPTH),
    .AW    (AW),
    .FW    (FW)
  ) u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_op          (in_op),
    .in_value       (in_value),
    .out_valid      (out_valid),
    .out_ok         (out_ok),
    .out_position   (out_position),
    .out_count      (out_count),
    .out_head_valid (out_head_valid),
    .out_head_value (out_head_value),
    .mem_we         (mem_we),
    .mem_waddr      (mem_waddr),
    .mem_wdata      (mem_wdata),
    .mem_raddr      (mem_raddr),
    .mem_rdata      (mem_rdata)
  );

  spq_mem #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

endmodule

@@ tb/tb.sv @@
// Self-checking testbench for sorted_priority_queue: directed items, then random traffic.
// A shadow copy of the sorted store predicts every result. Depends on spq_pkg and the RTL.
`timescale 1ns / 100ps

module tb;

  localparam int DEPTH = spq_pkg::DEPTH_DEF;

  typedef struct {
    logic                               ok;
    logic [spq_pkg::POS_W-1:0]          position;
    logic [spq_pkg::CNT_W-1:0]          count;
    logic                               head_valid;
    logic signed [spq_pkg::VALUE_W-1:0] head_value;
  } queue_status_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic [1:0] in_op = spq_pkg::OP_NONE;
  logic signed [spq_pkg::VALUE_W-1:0] in_value = '0;
  logic busy;
  logic out_valid;
  logic out_ok;
  logic [spq_pkg::POS_W-1:0] out_position;
  logic [spq_pkg::CNT_W-1:0] out_count;
  logic out_head_valid;
  logic signed [spq_pkg::VALUE_W-1:0] out_head_value;

  logic signed [spq_pkg::VALUE_W-1:0] sorted_copy [DEPTH];
  int copy_fill = 0;
  queue_status_t pending_status[$];
  int mismatches = 0;
  int results_seen = 0;
  bit sender_idles = 1'b1;

  sorted_priority_queue u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_op          (in_op),
    .in_value       (in_value),
    .out_valid      (out_valid),
    .out_ok         (out_ok),
    .out_position   (out_position),
    .out_count      (out_count),
    .out_head_valid (out_head_valid),
    .out_head_value (out_head_value)
  );

  always #6 clk = ~clk;

  // Applies one operation to the shadow store and returns the status it should report.
  function automatic queue_status_t queue_update(spq_pkg::op_t op,
                                                 logic signed [spq_pkg::VALUE_W-1:0] key);
    queue_status_t st;
    int i;
    int j;
    st.ok = 1'b0;
    st.position = '0;
    case (op)
      spq_pkg::OP_INSERT: begin
        if (copy_fill < DEPTH) begin
          // The new key goes ahead of any entry that is less than or equal to it.
          i = 0;
          while (i < copy_fill && sorted_copy[i] > key) i++;
          for (j = copy_fill; j > i; j--) sorted_copy[j] = sorted_copy[j-1];
          sorted_copy[i] = key;
          copy_fill++;
          st.ok = 1'b1;
          st.position = spq_pkg::POS_W'(i);
        end
      end
      spq_pkg::OP_REMOVE, spq_pkg::OP_FIND: begin
        i = 0;
        while (i < copy_fill && sorted_copy[i] !== key) i++;
        if (i < copy_fill) begin
          st.ok = 1'b1;
          st.position = spq_pkg::POS_W'(i);
          if (op == spq_pkg::OP_REMOVE) begin
            for (j = i; j + 1 < copy_fill; j++) sorted_copy[j] = sorted_copy[j+1];
            copy_fill--;
          end
        end
      end
      default: ;
    endcase
    st.count = spq_pkg::CNT_W'(copy_fill);
    st.head_valid = (copy_fill != 0);
    st.head_value = (copy_fill != 0) ? sorted_copy[0] : '0;
    return st;
  endfunction

  task automatic send_item(input spq_pkg::op_t op,
                           input logic signed [spq_pkg::VALUE_W-1:0] key);
    int unsigned gap;
    gap = sender_idles ? $urandom_range(18, 0) : 0;
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_op <= op;
    in_value <= key;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_status.push_back(queue_update(op, key));
  endtask

  // Stops sending, so that the item last sent is not taken a second time.
  task automatic wait_for_results;
    start <= 1'b0;
    @(posedge clk);
    while (pending_status.size() != 0) @(posedge clk);
  endtask

  task automatic report_field(input string field,
                              input logic signed [spq_pkg::VALUE_W-1:0] want,
                              input logic signed [spq_pkg::VALUE_W-1:0] got);
    mismatches++;
    $display("%0t: result %0d %s expected %0d got %0d", $time, results_seen, field, want, got);
  endtask

  always @(posedge clk) begin : check_results
    queue_status_t want;
    if (rst_n && out_valid) begin
      if (pending_status.size() == 0) begin
        mismatches++;
        $display("%0t: result with no item outstanding, expected none got ok %0d count %0d",
                 $time, out_ok, out_count);
      end else begin
        want = pending_status.pop_front();
        if (out_ok !== want.ok) report_field("ok", 32'(want.ok), 32'(out_ok));
        if (out_position !== want.position)
          report_field("position", 32'(want.position), 32'(out_position));
        if (out_count !== want.count)
          report_field("count", 32'(want.count), 32'(out_count));
        if (out_head_valid !== want.head_valid)
          report_field("head_valid", 32'(want.head_valid), 32'(out_head_valid));
        if (out_head_value !== want.head_value)
          report_field("head_value", want.head_value, out_head_value);
      end
      results_seen++;
    end
  end

  // Removes and searches mostly hit stored keys; small keys give plenty of duplicates.
  function automatic logic signed [spq_pkg::VALUE_W-1:0] pick_key(spq_pkg::op_t op);
    int unsigned roll;
    roll = $urandom_range(99, 0);
    if (op != spq_pkg::OP_INSERT && copy_fill != 0 && roll < 55)
      return sorted_copy[$urandom_range(copy_fill - 1, 0)];
    if (roll < 75) return int'($urandom_range(6, 0)) - 3;
    if (roll < 82) return roll[0] ? 32'sh7FFFFFFF : 32'sh80000000;
    return $urandom();
  endfunction

  task automatic test_empty_queue;
    send_item(spq_pkg::OP_REMOVE, 5);
    send_item(spq_pkg::OP_FIND, 0);
    send_item(spq_pkg::OP_NONE, -1);
  endtask

  task automatic test_extremes;
    send_item(spq_pkg::OP_INSERT, 32'sh7FFFFFFF);
    send_item(spq_pkg::OP_INSERT, 32'sh80000000);
    send_item(spq_pkg::OP_INSERT, 0);
    send_item(spq_pkg::OP_INSERT, 0);
    send_item(spq_pkg::OP_FIND, 0);
    send_item(spq_pkg::OP_FIND, 1);
    send_item(spq_pkg::OP_REMOVE, 32'sh80000000);
    // Smaller than everything stored, so it lands at the tail.
    send_item(spq_pkg::OP_INSERT, -5);
  endtask

  task automatic test_full_store;
    while (copy_fill < DEPTH) send_item(spq_pkg::OP_INSERT, $urandom());
    send_item(spq_pkg::OP_INSERT, 32'sh7FFFFFFF);
    send_item(spq_pkg::OP_FIND, 32'sh7FFFFFFF);
  endtask

  task automatic test_random_traffic(input int n_items);
    int k;
    int unsigned roll;
    bit draining;
    spq_pkg::op_t op;
    draining = 1'b1;
    for (k = 0; k < n_items; k++) begin
      if (k % 40 == 0) sender_idles = ($urandom_range(3, 0) != 0);
      if (k % 200 == 100 && $urandom_range(1, 0) == 0) wait_for_results();
      // Sweep between empty and full so that both ends are visited often.
      if (draining && copy_fill == 0 && $urandom_range(9, 0) == 0) draining = 1'b0;
      if (!draining && copy_fill == DEPTH && $urandom_range(9, 0) == 0) draining = 1'b1;
      roll = $urandom_range(99, 0);
      if (roll < 5) op = spq_pkg::OP_NONE;
      else if (roll < 20) op = spq_pkg::OP_FIND;
      else if (roll < 35) op = draining ? spq_pkg::OP_INSERT : spq_pkg::OP_REMOVE;
      else op = draining ? spq_pkg::OP_REMOVE : spq_pkg::OP_INSERT;
      send_item(op, pick_key(op));
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    test_empty_queue();
    test_extremes();
    test_full_store();
    wait_for_results();
    test_random_traffic(1625);
    wait_for_results();
    repeat (40) @(posedge clk);
    if (mismatches == 0 && pending_status.size() == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

  initial begin
    #20_000_000;
    $display("status: fail");
    $finish;
  end

endmodule
